/* src/two_stage_heating_thermostat_defines.svh */
// Assertion macros shared by the thermostat RTL.
`ifndef TWO_STAGE_HEATING_THERMOSTAT_DEFINES_SVH
`define TWO_STAGE_HEATING_THERMOSTAT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low
`define TSHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low
`define TSHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/tsht_pkg.sv */
// Types and constants of the two-stage heating thermostat.
package tsht_pkg;

  // Stage search: count of stages is a power of two so the step is a shift
  localparam int STAGE_SHIFT   = 2;
  localparam int MAX_STAGES    = 1 << STAGE_SHIFT;
  localparam int STAGE_W       = $clog2(MAX_STAGES + 1);
  localparam int PULSE_SECONDS = 8;
  localparam int SECS_W        = 8;
  localparam int BUDGET_W      = 6;
  localparam int BUDGET_MAX    = 63;

  // Signed working width for temperatures, thresholds and marks
  localparam int WIDE_W = 11;
  typedef logic signed [WIDE_W-1:0] swide_t;

  localparam swide_t ERR_LIMIT = -11'sd120;

  // Heating state
  typedef enum logic [1:0] {
    HEAT_OFF = 2'd0,
    HEAT_REG = 2'd1,
    HEAT_PER = 2'd2,
    HEAT_ERR = 2'd3
  } heat_e;

  // Run modes (code three behaves as pulse)
  localparam logic [1:0] MODE_ALT = 2'd0;
  localparam logic [1:0] MODE_LIN = 2'd1;
  localparam logic [1:0] MODE_PLS = 2'd2;

  // Item kinds
  localparam logic CMD_MEAS = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_THR_REG   = 3'd0,
    CFG_THR_PER   = 3'd1,
    CFG_RUN_MODE  = 3'd2,
    CFG_ACT_ABOVE = 3'd3,
    CFG_HYST      = 3'd4
  } cfg_idx_e;

  // Configuration as seen by the datapath; thr_per is already clamped
  typedef struct packed {
    logic signed [7:0] thr_reg;
    logic signed [7:0] thr_per;
    logic [1:0]        run_mode;
    logic              act_above;
    logic [4:0]        hyst;
  } cfg_t;

  // Sign-extend an 8-bit temperature to the working width
  function automatic swide_t sx8(logic signed [7:0] v);
    return swide_t'(v);
  endfunction

endpackage

/* src/tsht_cfg.sv */
// Configuration registers with clamping of the periodic bound.
module tsht_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  output tsht_pkg::cfg_t      cfg_o
);

  logic signed [7:0] thr_reg_q;
  logic signed [7:0] thr_per_q;
  logic [1:0]        run_mode_q;
  logic              act_above_q;
  logic [4:0]        hyst_q;
  logic signed [7:0] per_clamp;

  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_reg_q   <= '0;
      thr_per_q   <= '0;
      run_mode_q  <= tsht_pkg::MODE_ALT;
      act_above_q <= 1'b0;
      hyst_q      <= 5'd8;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tsht_pkg::CFG_THR_REG:   thr_reg_q   <= cfg_data_i;
        tsht_pkg::CFG_THR_PER:   thr_per_q   <= cfg_data_i;
        tsht_pkg::CFG_RUN_MODE:  run_mode_q  <= cfg_data_i[1:0];
        tsht_pkg::CFG_ACT_ABOVE: act_above_q <= cfg_data_i[0];
        tsht_pkg::CFG_HYST:      hyst_q      <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Periodic bound never sits on the heating side of the regular one
  always_comb begin
    per_clamp = thr_per_q;
    if (act_above_q) begin
      if (thr_per_q > thr_reg_q) per_clamp = thr_reg_q;
    end else begin
      if (thr_per_q < thr_reg_q) per_clamp = thr_reg_q;
    end
  end

  assign cfg_o.thr_reg   = thr_reg_q;
  assign cfg_o.thr_per   = per_clamp;
  assign cfg_o.run_mode  = run_mode_q;
  assign cfg_o.act_above = act_above_q;
  assign cfg_o.hyst      = hyst_q;

endmodule

/* src/tsht_budget.sv */
// Heating stage search and pulse budget for the periodic state.
module tsht_budget (
  input  logic signed [7:0]            temp_i,
  input  tsht_pkg::cfg_t               cfg_i,
  output logic [tsht_pkg::BUDGET_W-1:0] budget_o
);

  localparam int WIDE_MSB = tsht_pkg::WIDE_W - 1;

  tsht_pkg::swide_t                t_w;
  tsht_pkg::swide_t                reg_w;
  tsht_pkg::swide_t                per_w;
  tsht_pkg::swide_t                diff;
  tsht_pkg::swide_t                off;
  tsht_pkg::swide_t                mark;
  logic [7:0]                      span;
  logic [7:0]                      step;
  logic [tsht_pkg::STAGE_W-1:0]    stages;
  logic [tsht_pkg::STAGE_W-1:0]    stage;
  logic                            pass;
  logic [tsht_pkg::SECS_W-1:0]     secs;

  // Span between the bounds, stage count and step
  always_comb begin
    t_w   = tsht_pkg::sx8(temp_i);
    reg_w = tsht_pkg::sx8(cfg_i.thr_reg);
    per_w = tsht_pkg::sx8(cfg_i.thr_per);
    diff  = reg_w - per_w;
    span  = diff[WIDE_MSB] ? 8'(-diff) : 8'(diff);
    if (span >= 8'(tsht_pkg::MAX_STAGES)) begin
      stages = tsht_pkg::STAGE_W'(tsht_pkg::MAX_STAGES);
      step   = span >> tsht_pkg::STAGE_SHIFT;
    end else begin
      stages = span[tsht_pkg::STAGE_W-1:0];
      step   = 8'd1;
    end
  end

  // Marks are monotonic, so the stage is one plus the marks passed
  always_comb begin
    stage = tsht_pkg::STAGE_W'(1);
    off   = '0;
    mark  = '0;
    pass  = 1'b0;
    for (int k = 1; k < tsht_pkg::MAX_STAGES; k++) begin
      off  = tsht_pkg::swide_t'(k) * tsht_pkg::swide_t'(step);
      mark = cfg_i.act_above ? (per_w + off) : (per_w - off);
      pass = (tsht_pkg::STAGE_W'(k) < stages) &&
             (cfg_i.act_above ? (t_w >= mark) : (t_w <= mark));
      stage = stage + tsht_pkg::STAGE_W'(pass);
    end
  end

  // Seconds of pulse heating, saturated to the budget range
  always_comb begin
    secs = tsht_pkg::SECS_W'(stage) * tsht_pkg::SECS_W'(tsht_pkg::PULSE_SECONDS);
    if (secs > tsht_pkg::SECS_W'(tsht_pkg::BUDGET_MAX)) begin
      budget_o = tsht_pkg::BUDGET_W'(tsht_pkg::BUDGET_MAX);
    end else begin
      budget_o = secs[tsht_pkg::BUDGET_W-1:0];
    end
  end

endmodule

/* src/two_stage_heating_thermostat.sv */
// Top level of the two-stage heating thermostat: item register, state and result register.
//
//  channel  | direction | beat contents
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | tuser: cmd (0 measure, 1 tick); tdata: temperature
//  m_axis   | out       | tdata: load_one, load_two, heat_state, pulse seconds
//  cfg      | in        | cfg_index_i register index, cfg_data_i value
//
//  One beat per cycle in and out while the output is not stalled; each input beat gives one output beat.
//  A beat waits in the input register; its result is loaded into the output
//  register when the beat advances, and is offered from there.
//  The state update for a beat is one pass of logic between the two registers.
//  A stalled output holds the input register; tready drops only when both are full.
//  Reset (rst_ni low, asynchronous) clears state, loads, budget and the valid flags of both registers.
`include "two_stage_heating_thermostat_defines.svh"

module two_stage_heating_thermostat (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] temperature
  input  logic [0:0]  s_axis_tuser_i,   // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [0] load_one, [1] load_two, [3:2] heat_state,
                                        // [9:4] pulse_seconds_left, [15:10] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  tsht_pkg::cfg_t                    cfg;
  logic                              in_vld_q;
  logic                              cmd_q;
  logic signed [7:0]                 temp_q;
  logic                              out_vld_q;
  logic [15:0]                       out_data_q;
  logic                              advance;
  logic                              pulse;
  tsht_pkg::heat_e                   state_q, state_d;
  logic [tsht_pkg::BUDGET_W-1:0]     budget_q, budget_d;
  logic [tsht_pkg::BUDGET_W-1:0]     stage_budget;
  logic                              load1_q, load1_d;
  logic                              load2_q, load2_d;
  tsht_pkg::swide_t                  t_w;
  tsht_pkg::swide_t                  reg_w;
  tsht_pkg::swide_t                  per_w;
  tsht_pkg::swide_t                  hy_w;

  tsht_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tsht_budget u_budget (
    .temp_i   (temp_q),
    .cfg_i    (cfg),
    .budget_o (stage_budget)
  );

  // Handshake: the item moves on when the result slot is free or draining
  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign pulse           = cfg.run_mode >= tsht_pkg::MODE_PLS;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      cmd_q  <= s_axis_tuser_i[0];
      temp_q <= s_axis_tdata_i;
    end
  end

  // Heating state, budget and load levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= tsht_pkg::HEAT_OFF;
      budget_q <= '0;
      load1_q  <= 1'b0;
      load2_q  <= 1'b0;
    end else if (advance) begin
      state_q  <= state_d;
      budget_q <= budget_d;
      load1_q  <= load1_d;
      load2_q  <= load2_d;
    end
  end

  // Next state for the item in the input register
  always_comb begin
    t_w      = tsht_pkg::sx8(temp_q);
    reg_w    = tsht_pkg::sx8(cfg.thr_reg);
    per_w    = tsht_pkg::sx8(cfg.thr_per);
    hy_w     = tsht_pkg::swide_t'(cfg.hyst);
    state_d  = state_q;
    budget_d = budget_q;
    load1_d  = load1_q;
    load2_d  = load2_q;
    if (cmd_q == tsht_pkg::CMD_MEAS) begin
      // State change with hysteresis, mirrored when acting above
      if (t_w <= tsht_pkg::ERR_LIMIT) begin
        state_d = tsht_pkg::HEAT_ERR;
      end else if (cfg.act_above ? (t_w >= reg_w) : (t_w <= reg_w)) begin
        state_d = tsht_pkg::HEAT_REG;
      end else if (state_q != tsht_pkg::HEAT_REG &&
                   (cfg.act_above ? (t_w >= per_w) : (t_w <= per_w))) begin
        state_d = tsht_pkg::HEAT_PER;
      end else begin
        if (cfg.act_above ? (t_w <= reg_w - hy_w) : (t_w >= reg_w + hy_w)) begin
          state_d = tsht_pkg::HEAT_PER;
        end
        if (cfg.act_above ? (t_w <= per_w) : (t_w >= per_w)) begin
          state_d = tsht_pkg::HEAT_OFF;
        end
      end
      budget_d = (state_d == tsht_pkg::HEAT_PER) ? stage_budget : '0;
      // Load drive by mode; periodic pulse leaves the loads to the ticks
      if (!pulse) begin
        case (state_d)
          tsht_pkg::HEAT_PER: begin
            load1_d = 1'b1;
            load2_d = 1'b0;
          end
          tsht_pkg::HEAT_REG: begin
            load1_d = (cfg.run_mode == tsht_pkg::MODE_LIN);
            load2_d = 1'b1;
          end
          default: begin
            load1_d = 1'b0;
            load2_d = 1'b0;
          end
        endcase
      end else begin
        case (state_d)
          tsht_pkg::HEAT_REG: begin
            load1_d = 1'b1;
            load2_d = 1'b1;
          end
          tsht_pkg::HEAT_PER: ;
          default: begin
            load1_d = 1'b0;
            load2_d = 1'b0;
          end
        endcase
      end
    end else if (state_q == tsht_pkg::HEAT_PER && pulse) begin
      // Tick spends one second of the budget with both loads on
      if (budget_q != '0) begin
        load1_d  = 1'b1;
        load2_d  = 1'b1;
        budget_d = budget_q - tsht_pkg::BUDGET_W'(1);
      end else begin
        load1_d = 1'b0;
        load2_d = 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {6'b0, budget_d, state_d, load2_d, load1_d};
    end
  end

  // Checks
  `TSHT_ASSERT_NOW(a_budget_only_periodic, state_q != tsht_pkg::HEAT_PER, budget_q == '0, "pulse budget held outside periodic state")
  `TSHT_ASSERT_NOW(a_err_loads_off, state_q == tsht_pkg::HEAT_ERR, !load1_q && !load2_q, "load on in sensor error state")
  `TSHT_ASSERT_NEXT(a_tick_spends_one, advance && cmd_q == tsht_pkg::CMD_TICK && state_q == tsht_pkg::HEAT_PER && pulse && budget_q != '0, budget_q == $past(budget_q) - tsht_pkg::BUDGET_W'(1), "tick did not spend one second")
  `TSHT_ASSERT_NEXT(a_item_held, in_vld_q && !advance, in_vld_q && $stable(temp_q) && $stable(cmd_q), "stalled item lost from input register")

endmodule

/* sim/tsht_state_check.sv */
// Thermostat checker: predicts each result beat from the input and config beats and compares.
`timescale 1ns / 1ps

module tsht_state_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,    // [7:0] temperature
  input  logic [0:0]  s_tuser_i,    // [0] cmd
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [15:0] m_tdata_i,    // [0] load_one, [1] load_two, [3:2] heat_state,
                                    // [9:4] pulse_seconds_left, [15:10] zero
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  output int          err_count_o,
  output int          outstanding_o
);

  // Predicted thermostat state
  tsht_pkg::heat_e st_q;
  logic [5:0]      budget_q;
  logic            lone_q;
  logic            ltwo_q;

  // Shadow copy of the config registers
  logic signed [7:0] c_reg;
  logic signed [7:0] c_per;
  logic [1:0]        c_mode;
  logic              c_above;
  logic [4:0]        c_hyst;

  // Expected result beats, oldest first
  logic [15:0] result_q[$];
  logic [15:0] want;

  initial err_count_o = 0;
  initial outstanding_o = 0;

  // Pulse seconds for the stage the temperature falls in (thresholds already clamped)
  function automatic int stage_secs(int t, int treg, int tper, logic above);
    int span;
    int step;
    int stages;
    int mark;
    int stage;
    int secs;
    span = treg - tper;
    if (span < 0) span = -span;
    if (span >= tsht_pkg::MAX_STAGES) begin
      stages = tsht_pkg::MAX_STAGES;
      step   = span / tsht_pkg::MAX_STAGES;
    end else begin
      stages = span;
      step   = 1;
    end
    mark  = above ? tper + step : tper - step;
    // stage 1 is the floor, even with no stages at all
    stage = 1;
    while (stage < stages && !(above ? (t < mark) : (t > mark))) begin
      mark  = above ? mark + step : mark - step;
      stage = stage + 1;
    end
    secs = stage * tsht_pkg::PULSE_SECONDS;
    if (secs > tsht_pkg::BUDGET_MAX) secs = tsht_pkg::BUDGET_MAX;
    return secs;
  endfunction

  // State and load update for a measurement beat
  task apply_measurement(input int t);
    int              treg;
    int              tper;
    int              h;
    tsht_pkg::heat_e nxt;
    logic            pulse;
    treg  = int'(c_reg);
    tper  = int'(c_per);
    h     = int'(c_hyst);
    nxt   = st_q;
    pulse = (c_mode >= tsht_pkg::MODE_PLS);
    // periodic bound never sits on the heating side of the regular one
    if (!c_above && tper < treg) tper = treg;
    if (c_above && tper > treg) tper = treg;

    if (t <= int'(tsht_pkg::ERR_LIMIT)) begin
      nxt = tsht_pkg::HEAT_ERR;
    end else if (c_above ? (t >= treg) : (t <= treg)) begin
      nxt = tsht_pkg::HEAT_REG;
    end else if (nxt != tsht_pkg::HEAT_REG && (c_above ? (t >= tper) : (t <= tper))) begin
      nxt = tsht_pkg::HEAT_PER;
    end else begin
      if (c_above ? (t <= treg - h) : (t >= treg + h)) nxt = tsht_pkg::HEAT_PER;
      if (c_above ? (t <= tper) : (t >= tper)) nxt = tsht_pkg::HEAT_OFF;
    end
    st_q     = nxt;
    budget_q = (nxt == tsht_pkg::HEAT_PER) ? 6'(stage_secs(t, treg, tper, c_above)) : 6'd0;

    if (!pulse) begin
      case (nxt)
        tsht_pkg::HEAT_PER: begin
          lone_q = 1'b1;
          ltwo_q = 1'b0;
        end
        tsht_pkg::HEAT_REG: begin
          lone_q = (c_mode == tsht_pkg::MODE_LIN);
          ltwo_q = 1'b1;
        end
        default: begin
          lone_q = 1'b0;
          ltwo_q = 1'b0;
        end
      endcase
    end else if (nxt == tsht_pkg::HEAT_REG) begin
      lone_q = 1'b1;
      ltwo_q = 1'b1;
    end else if (nxt != tsht_pkg::HEAT_PER) begin
      lone_q = 1'b0;
      ltwo_q = 1'b0;
    end
    // periodic pulse: loads left to the ticks
  endtask

  // One-second tick spends the pulse budget in periodic pulse mode only
  task apply_tick();
    if (st_q == tsht_pkg::HEAT_PER && c_mode >= tsht_pkg::MODE_PLS) begin
      if (budget_q != 6'd0) begin
        lone_q   = 1'b1;
        ltwo_q   = 1'b1;
        budget_q = budget_q - 6'd1;
      end else begin
        lone_q = 1'b0;
        ltwo_q = 1'b0;
      end
    end
  endtask

  task check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      err_count_o++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     = tsht_pkg::HEAT_OFF;
      budget_q = '0;
      lone_q   = 1'b0;
      ltwo_q   = 1'b0;
      c_reg    = '0;
      c_per    = '0;
      c_mode   = tsht_pkg::MODE_ALT;
      c_above  = 1'b0;
      c_hyst   = 5'd8;
      result_q.delete();
    end else begin
      // result beat against the oldest expectation
      if (m_tvalid_i && m_tready_i) begin
        if (result_q.size() == 0) begin
          err_count_o++;
          $display("%0t: result beat expected none actual %h", $time, m_tdata_i);
        end else begin
          want = result_q.pop_front();
          check_field("load_one", int'(want[0]), int'(m_tdata_i[0]));
          check_field("load_two", int'(want[1]), int'(m_tdata_i[1]));
          check_field("heat_state", int'(want[3:2]), int'(m_tdata_i[3:2]));
          check_field("pulse_seconds_left", int'(want[9:4]), int'(m_tdata_i[9:4]));
          check_field("pad bits", int'(want[15:10]), int'(m_tdata_i[15:10]));
        end
      end

      // config write
      if (cfg_valid_i && cfg_ready_i) begin
        case (tsht_pkg::cfg_idx_e'(cfg_index_i))
          tsht_pkg::CFG_THR_REG:   c_reg   = cfg_data_i;
          tsht_pkg::CFG_THR_PER:   c_per   = cfg_data_i;
          tsht_pkg::CFG_RUN_MODE:  c_mode  = cfg_data_i[1:0];
          tsht_pkg::CFG_ACT_ABOVE: c_above = cfg_data_i[0];
          tsht_pkg::CFG_HYST:      c_hyst  = cfg_data_i[4:0];
          default: ;
        endcase
      end

      // input beat: predict its result
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i[0] == tsht_pkg::CMD_MEAS) apply_measurement(int'($signed(s_tdata_i)));
        else apply_tick();
        result_q.push_back({6'b0, budget_q, st_q, ltwo_q, lone_q});
      end
    end
    outstanding_o = result_q.size();
  end

endmodule

/* sim/two_stage_heating_thermostat_test.sv */
// Testbench top for the thermostat: clock, reset, config phases, item stimulus and verdict.
`timescale 1ns / 1ps

module two_stage_heating_thermostat_test;

  // run mode code three has no package name; it behaves as pulse
  localparam logic [1:0] MODE_THREE = 2'd3;
  localparam int         N_PHASES   = 14;
  localparam int         PHASE_BEATS = 72;
  localparam int         HOLD_CYCLES = 80;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic [0:0]  s_user = '0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  int   err_count;
  int   outstanding;
  bit   calm = 1'b0;      // no idling on either side while set
  bit   hold_req = 1'b0;  // asks the receiver for a long stall

  // phase config, kept here to aim temperatures at the thresholds
  int   p_reg;
  int   p_per;
  int   p_hyst;

  two_stage_heating_thermostat dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  tsht_state_check state_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_valid),
    .s_tready_i    (s_ready),
    .s_tdata_i     (s_data),
    .s_tuser_i     (s_user),
    .m_tvalid_i    (m_valid),
    .m_tready_i    (m_ready),
    .m_tdata_i     (m_data),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .err_count_o   (err_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Register write beat; valid stays up for the next write, caller lowers it
  task write_reg(input tsht_pkg::cfg_idx_e idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
  endtask

  task program_cfg(input int treg, input int tper, input logic [1:0] mode,
                   input logic above, input int hyst);
    write_reg(tsht_pkg::CFG_THR_REG, 8'(treg));
    write_reg(tsht_pkg::CFG_THR_PER, 8'(tper));
    write_reg(tsht_pkg::CFG_RUN_MODE, {6'b0, mode});
    write_reg(tsht_pkg::CFG_ACT_ABOVE, {7'b0, above});
    write_reg(tsht_pkg::CFG_HYST, 8'(hyst));
    cfg_valid <= 1'b0;
    p_reg  = treg;
    p_per  = tper;
    p_hyst = hyst;
  endtask

  // One input beat, after a random gap
  task send_item(input logic cmd, input logic [7:0] temp);
    int gap;
    gap = calm ? 0 : $urandom_range(14);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= temp;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task measure(input int t);
    send_item(tsht_pkg::CMD_MEAS, 8'(t));
  endtask

  task ticks(input int n);
    repeat (n) send_item(tsht_pkg::CMD_TICK, 8'($urandom));
  endtask

  // Lower valid and wait until every expected result has arrived
  task drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Temperature near the thresholds and the hysteresis band
  function automatic int near_temp();
    int lo;
    int hi;
    lo = ((p_reg < p_per) ? p_reg : p_per) - p_hyst - 6;
    hi = ((p_reg > p_per) ? p_reg : p_per) + p_hyst + 6;
    if (lo < -128) lo = -128;
    if (hi > 127) hi = 127;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Receiver: random stalls, rare long hold-off
  initial begin
    int stall;
    int hold_cnt;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        m_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk_i);
        hold_req = 1'b0;
      end
      stall = calm ? 0 : $urandom_range(14);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_valid) @(posedge clk_i);
    end
  end

  // Stimulus and verdict
  initial begin
    int sent;
    int r;
    int treg;
    int tper;
    logic above;
    p_reg  = 0;
    p_per  = 0;
    p_hyst = 8;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: error limit, regular at threshold, off above it
    measure(127);
    measure(0);
    ticks(1);
    measure(-120);
    measure(-119);
    measure(5);
    measure(-128);
    drain();

    // pulse mode, heating below: stage search, budget spent by ticks
    program_cfg(10, 30, tsht_pkg::MODE_PLS, 1'b0, 5);
    measure(20);
    ticks(3);
    measure(5);
    measure(12);
    measure(16);
    ticks(2);
    drain();

    // mode three, mirrored, narrow span, no hysteresis
    program_cfg(-10, -13, MODE_THREE, 1'b1, 0);
    measure(-128);
    measure(0);
    measure(-11);
    ticks(2);
    measure(-13);
    ticks(1);
    measure(50);
    drain();

    // Random phases
    for (int ph = 0; ph < N_PHASES; ph++) begin
      above = 1'($urandom_range(1));
      case (ph)
        0: program_cfg(-128, 127, tsht_pkg::MODE_ALT, 1'b0, 0);
        1: program_cfg(127, -128, tsht_pkg::MODE_LIN, 1'b1, 31);
        2: program_cfg(127, -128, tsht_pkg::MODE_PLS, 1'b0, 31);
        3: program_cfg(-128, 127, MODE_THREE, 1'b1, 0);
        default: begin
          treg = int'($urandom_range(120)) - 60;
          if ($urandom_range(4) == 0) begin
            tper = int'($urandom_range(255)) - 128;
          end else begin
            // periodic bound on the far side of the regular one
            tper = above ? treg - int'($urandom_range(40)) : treg + int'($urandom_range(40));
          end
          program_cfg(treg, tper, 2'($urandom_range(3)), above, $urandom_range(31));
        end
      endcase

      calm = ($urandom_range(3) == 0);
      if (ph == 4) begin
        calm     = 1'b1;
        hold_req = 1'b1;
      end

      sent = 0;
      while (sent < PHASE_BEATS) begin
        r = $urandom_range(99);
        if (r < 55) begin
          measure(near_temp());
          sent++;
        end else if (r < 65) begin
          measure(int'($urandom_range(255)) - 128);
          sent++;
        end else begin
          // tick burst, sometimes long enough to empty the full budget
          r = ($urandom_range(9) == 0) ? 40 : 1 + int'($urandom_range(11));
          ticks(r);
          sent += r;
        end
        if ($urandom_range(15) == 0) calm = ~calm;
      end
      drain();
    end

    calm = 1'b0;
    repeat (10) @(posedge clk_i);
    if (err_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/tsht_pkg.sv
src/tsht_cfg.sv
src/tsht_budget.sv
src/two_stage_heating_thermostat.sv
sim/tsht_state_check.sv
sim/two_stage_heating_thermostat_test.sv
